// ----- hdl/tzp_pkg.sv -----
// Shared types, constants and helper functions for the torus z-buffer plotter.
// Depends on nothing; every other file of the block imports it.
package tzp_pkg;

  localparam int COLS      = 80;
  localparam int ROWS      = 22;
  localparam int CELLS     = COLS * ROWS;
  localparam int CELL_W    = $clog2(CELLS + 1);
  localparam int ADDR_W    = $clog2(CELLS);
  localparam int Q_W       = 16;
  localparam int DEPTH_W   = 16;
  localparam int GLYPH_W   = 7;
  localparam int CFG_IDX_W = 2;

  localparam logic [GLYPH_W-1:0] GLYPH_SPACE   = GLYPH_W'(32);
  localparam logic [GLYPH_W-1:0] GLYPH_NEWLINE = GLYPH_W'(10);

  localparam int RECIP_SH = 18;
  localparam int RECIP    = (2 ** RECIP_SH + COLS - 1) / COLS;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SIN_TILT,
    REG_COS_TILT,
    REG_SIN_SPIN,
    REG_COS_SPIN
  } cfg_reg_e;

  typedef struct packed {
    logic                  mode;
    logic [CELL_W-1:0]     cell_index;
    logic signed [Q_W-1:0] sin_tube;
    logic signed [Q_W-1:0] cos_tube;
    logic signed [Q_W-1:0] sin_ring;
    logic signed [Q_W-1:0] cos_ring;
  } sample_t;

  typedef struct packed {
    logic                plotted;
    logic [CELL_W-1:0]   target_cell;
    logic [GLYPH_W-1:0]  glyph;
  } result_t;

  typedef struct packed {
    logic signed [Q_W-1:0] sin_tilt;
    logic signed [Q_W-1:0] cos_tilt;
    logic signed [Q_W-1:0] sin_spin;
    logic signed [Q_W-1:0] cos_spin;
  } frame_t;

  typedef struct packed {
    logic                in_bounds;
    logic [CELL_W-1:0]   cell_num;
    logic [DEPTH_W-1:0]  depth;
    logic [GLYPH_W-1:0]  glyph;
  } plot_t;

  typedef struct packed {
    logic [GLYPH_W-1:0] glyph;
    logic [DEPTH_W-1:0] depth;
  } cell_t;

  function automatic logic [GLYPH_W-1:0] shade_glyph(input logic [3:0] idx);
    logic [GLYPH_W-1:0] g;
    case (idx)
      4'd0:    g = GLYPH_W'(46);
      4'd1:    g = GLYPH_W'(44);
      4'd2:    g = GLYPH_W'(45);
      4'd3:    g = GLYPH_W'(126);
      4'd4:    g = GLYPH_W'(58);
      4'd5:    g = GLYPH_W'(59);
      4'd6:    g = GLYPH_W'(61);
      4'd7:    g = GLYPH_W'(33);
      4'd8:    g = GLYPH_W'(42);
      4'd9:    g = GLYPH_W'(35);
      4'd10:   g = GLYPH_W'(36);
      default: g = GLYPH_W'(64);
    endcase
    return g;
  endfunction

  // True when k is a multiple of the row width, found through a reciprocal.
  function automatic logic is_row_start(input logic [CELL_W-1:0] k);
    logic [CELL_W+RECIP_SH:0] prod;
    logic [CELL_W:0]          quot;
    logic [CELL_W:0]          back;
    prod = (CELL_W + RECIP_SH + 1)'(k) * (CELL_W + RECIP_SH + 1)'(RECIP);
    quot = prod[CELL_W+RECIP_SH:RECIP_SH];
    back = (CELL_W + 1)'(quot * (CELL_W + 1)'(COLS));
    return back == {1'b0, k};
  endfunction

endpackage

// ----- hdl/tzp_stream_if.sv -----
// Valid/ready channel interfaces for the sample and result words.
// Depends on tzp_pkg for the payload types.
interface tzp_sample_if;
  import tzp_pkg::*;
  logic    valid;
  logic    ready;
  sample_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface tzp_result_if;
  import tzp_pkg::*;
  logic    valid;
  logic    ready;
  result_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ----- hdl/tzp_recip.sv -----
// Bit-serial restoring divider giving the saturated reciprocal depth 2^58 / den.
// Depends on tzp_pkg.
module tzp_recip (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic signed [49:0]            den,
  output logic                          done,
  output logic [tzp_pkg::DEPTH_W-1:0]   quot
);
  import tzp_pkg::*;

  localparam int CNT_W = $clog2(DEPTH_W);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [48:0]      rem;
  logic [48:0]      dv;
  logic [49:0]      rem2;

  assign rem2 = {rem, 1'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      cnt <= '0;
      if (den <= 50'sd0) begin
        quot <= '0;
        done <= 1'b1;
      end else if (den <= (50'sd1 <<< 42)) begin
        quot <= '1;
        done <= 1'b1;
      end else begin
        rem  <= 49'(1) << 42;
        dv   <= den[48:0];
        quot <= '0;
        busy <= 1'b1;
        done <= 1'b0;
      end
    end else if (busy) begin
      if (rem2 >= {1'b0, dv}) begin
        rem  <= 49'(rem2 - {1'b0, dv});
        quot <= {quot[DEPTH_W-2:0], 1'b1};
      end else begin
        rem  <= rem2[48:0];
        quot <= {quot[DEPTH_W-2:0], 1'b0};
      end
      cnt <= cnt + CNT_W'(1);
      if (cnt == CNT_W'(DEPTH_W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end
endmodule

// ----- hdl/tzp_geom.sv -----
// Projection sequencer: one shared 36x18 multiplier steps through the torus
// geometry, and a reciprocal unit supplies the depth. Depends on tzp_pkg, tzp_recip.
module tzp_geom (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  tzp_pkg::sample_t  smp,
  input  tzp_pkg::frame_t   frm,
  output logic              done,
  output tzp_pkg::plot_t    plot
);
  import tzp_pkg::*;

  typedef enum logic [4:0] {
    P_SH, P_SD, P_CH, P_FG, P_FE, P_CD, P_SHE, P_SHG, P_SDG, P_CHM, P_TN,
    P_CHN, P_TM, P_QM, P_SDE, P_CDN, P_LUM, P_DPX, P_DPY, P_Y, P_OUT
  } step_e;

  step_e step;
  logic  busy;

  logic signed [Q_W-1:0] s, c, f, d;
  logic signed [17:0]    h;
  logic signed [35:0]    a_op;
  logic signed [17:0]    b_op;
  logic signed [53:0]    p;
  logic signed [35:0]    sh, sd, ch, fg, fe, cd, t, q, px, py;
  logic signed [49:0]    den;
  logic signed [55:0]    acc, lum;
  logic signed [23:0]    x, y;
  logic signed [63:0]    fg14, fe14, prod64, xs, ys;
  logic                  recip_done;
  logic [DEPTH_W-1:0]    dval;
  logic signed [17:0]    dop;
  logic signed [16:0]    lum_hi;
  logic [3:0]            shade;

  function automatic logic signed [23:0] trunc36(input logic signed [63:0] v);
    logic signed [63:0] r;
    if (v < 64'sd0) r = (v + ((64'sd1 <<< 36) - 64'sd1)) >>> 36;
    else r = v >>> 36;
    return r[23:0];
  endfunction

  tzp_recip u_recip (
    .clk   (clk),
    .rst   (rst),
    .start (busy && step == P_SDG),
    .den   (den),
    .done  (recip_done),
    .quot  (dval)
  );

  assign h      = 18'(d) + 18'sd32768;
  assign dop    = $signed({2'b00, dval});
  assign fg14   = 64'(fg) <<< 14;
  assign fe14   = 64'(fe) <<< 14;
  assign prod64 = 64'(p);
  assign xs     = (64'sd40 <<< 36) + prod64 * 64'sd30;
  assign ys     = (64'sd12 <<< 36) + prod64 * 64'sd15;
  assign lum_hi = lum[55:39];

  always_comb begin
    if (lum < 56'sd0) shade = 4'd0;
    else if (lum_hi > 17'sd11) shade = 4'd11;
    else shade = lum_hi[3:0];
  end

  always_comb begin
    a_op = '0;
    b_op = '0;
    unique case (step)
      P_SH:    begin a_op = 36'(s);  b_op = h;        end
      P_SD:    begin a_op = 36'(s);  b_op = 18'(d);   end
      P_CH:    begin a_op = 36'(c);  b_op = h;        end
      P_FG:    begin a_op = 36'(f);  b_op = 18'(frm.cos_tilt); end
      P_FE:    begin a_op = 36'(f);  b_op = 18'(frm.sin_tilt); end
      P_CD:    begin a_op = 36'(c);  b_op = 18'(d);   end
      P_SHE:   begin a_op = sh;      b_op = 18'(frm.sin_tilt); end
      P_SHG:   begin a_op = sh;      b_op = 18'(frm.cos_tilt); end
      P_SDG:   begin a_op = sd;      b_op = 18'(frm.cos_tilt); end
      P_CHM:   begin a_op = ch;      b_op = 18'(frm.cos_spin); end
      P_TN:    begin a_op = t;       b_op = 18'(frm.sin_spin); end
      P_CHN:   begin a_op = ch;      b_op = 18'(frm.sin_spin); end
      P_TM:    begin a_op = t;       b_op = 18'(frm.cos_spin); end
      P_QM:    begin a_op = q;       b_op = 18'(frm.cos_spin); end
      P_SDE:   begin a_op = sd;      b_op = 18'(frm.sin_tilt); end
      P_CDN:   begin a_op = cd;      b_op = 18'(frm.sin_spin); end
      P_LUM:   begin a_op = px;      b_op = dop;      end
      P_DPX:   begin a_op = px;      b_op = dop;      end
      P_DPY:   begin a_op = py;      b_op = dop;      end
      P_Y:     begin a_op = py;      b_op = dop;      end
      P_OUT:   begin a_op = px;      b_op = dop;      end
      default: begin a_op = '0;      b_op = '0;       end
    endcase
  end

  always_ff @(posedge clk) begin
    p <= a_op * b_op;
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= P_SH;
    end else begin
      done <= 1'b0;
      if (!busy) begin
        if (start) begin
          busy <= 1'b1;
          step <= P_SH;
          s    <= smp.sin_tube;
          c    <= smp.cos_tube;
          f    <= smp.sin_ring;
          d    <= smp.cos_ring;
        end
      end else begin
        step <= step_e'(step + 5'd1);
        unique case (step)
          P_SH:  ;
          P_SD:  sh <= 36'(p);
          P_CH:  sd <= 36'(p);
          P_FG:  ch <= 36'(p);
          P_FE:  fg <= 36'(p);
          P_CD:  fe <= 36'(p);
          P_SHE: cd <= 36'(p);
          P_SHG: den <= 50'(prod64 + fg14 + (64'sd5 <<< 42));
          P_SDG: t <= 36'((prod64 - fe14) >>> 14);
          P_CHM: q <= 36'((fe14 - prod64) >>> 14);
          P_TN:  acc <= 56'(p);
          P_CHN: px <= 36'((64'(acc) - prod64) >>> 22);
          P_TM:  acc <= 56'(p);
          P_QM:  py <= 36'((64'(acc) + prod64) >>> 22);
          P_SDE: acc <= 56'(prod64 - fg14);
          P_CDN: acc <= acc - 56'(p);
          P_LUM: lum <= acc - 56'(p);
          P_DPX: begin
            if (!recip_done) step <= P_DPX;
          end
          P_DPY: x <= trunc36(xs);
          P_Y:   y <= trunc36(ys);
          P_OUT: begin
            busy           <= 1'b0;
            done           <= 1'b1;
            step           <= P_SH;
            plot.in_bounds <= (x > 24'sd0) && (x < 24'(COLS)) &&
                              (y > 24'sd0) && (y < 24'(ROWS));
            plot.cell_num  <= CELL_W'(x) + CELL_W'(y) * CELL_W'(COLS);
            plot.depth     <= dval;
            plot.glyph     <= shade_glyph(shade);
          end
          default: step <= P_SH;
        endcase
      end
    end
  end
endmodule

// ----- hdl/tzp_store.sv -----
// Cell store: glyph and depth of every screen cell in one synchronous memory.
// Depends on tzp_pkg.
module tzp_store (
  input  logic                        clk,
  input  logic                        rd_en,
  input  logic [tzp_pkg::ADDR_W-1:0]  rd_addr,
  output tzp_pkg::cell_t              rd_data,
  input  logic                        wr_en,
  input  logic [tzp_pkg::ADDR_W-1:0]  wr_addr,
  input  tzp_pkg::cell_t              wr_data
);
  import tzp_pkg::*;

  cell_t mem [CELLS];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data <= mem[rd_addr];
  end
endmodule

// ----- hdl/torus_zbuffer_plotter_unit.sv -----
// Top level of the torus z-buffer plotter: configuration, control and result register.
// Depends on tzp_pkg, tzp_stream_if, tzp_geom and tzp_store.
//
//   port        dir   handshake          word
//   sample      in    valid/ready        tzp_pkg::sample_t
//   result      out   valid/ready        tzp_pkg::result_t
//   cfg_*       in    cfg_wr_en only     cfg_index, cfg_data
//
// A plot word passes from acceptance to the next acceptance through 21 steps of the
// shared multiplier, a wait on the 16-step reciprocal divider, then one store read
// and the result state. The store read is skipped when the sample falls off screen,
// and the wait when the divider is bypassed. A read word that lies in the store goes
// through the store read, ST_LOOK and ST_DONE. One word is in flight at a time.
// After reset a clearing pass writes every one of the 1760 cells, one per cycle,
// with sample.ready low. A stalled result holds the block in its final state.
module torus_zbuffer_plotter_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wr_en,
  input  logic [tzp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tzp_pkg::Q_W-1:0]        cfg_data,
  tzp_sample_if.sink                     sample,
  tzp_result_if.source                   result
);
  import tzp_pkg::*;

  typedef enum logic [2:0] {ST_CLEAR, ST_IDLE, ST_GEOM, ST_LOOK, ST_DONE} state_e;

  state_e             state;
  frame_t             frm;
  logic [ADDR_W-1:0]  clr_addr;
  logic               cur_read;
  logic               cur_nl;
  logic [CELL_W-1:0]  cur_cell;
  result_t            res;
  logic               out_valid;
  result_t            out_word;
  logic               accept;
  logic               geom_done;
  plot_t              plot;
  logic               mem_rd_en;
  logic [ADDR_W-1:0]  mem_rd_addr;
  cell_t              mem_rd_data;
  logic               mem_wr_en;
  logic [ADDR_W-1:0]  mem_wr_addr;
  cell_t              mem_wr_data;
  logic               in_store;
  logic               hit;

  assign sample.ready   = (state == ST_IDLE);
  assign accept         = sample.valid && sample.ready;
  assign result.valid   = out_valid;
  assign result.payload = out_word;
  assign in_store       = sample.payload.cell_index < CELL_W'(CELLS);
  assign hit            = plot.depth > mem_rd_data.depth;

  tzp_geom u_geom (
    .clk   (clk),
    .rst   (rst),
    .start (accept && !sample.payload.mode),
    .smp   (sample.payload),
    .frm   (frm),
    .done  (geom_done),
    .plot  (plot)
  );

  tzp_store u_store (
    .clk     (clk),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data)
  );

  always_comb begin
    mem_rd_en   = 1'b0;
    mem_rd_addr = ADDR_W'(plot.cell_num);
    mem_wr_en   = 1'b0;
    mem_wr_addr = ADDR_W'(cur_cell);
    mem_wr_data = '{glyph: GLYPH_SPACE, depth: '0};
    unique case (state)
      ST_CLEAR: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = clr_addr;
      end
      ST_IDLE: begin
        mem_rd_en   = accept && sample.payload.mode && in_store;
        mem_rd_addr = ADDR_W'(sample.payload.cell_index);
      end
      ST_GEOM: mem_rd_en = geom_done && plot.in_bounds;
      ST_LOOK: begin
        if (cur_read) begin
          mem_wr_en = 1'b1;
        end else if (hit) begin
          mem_wr_en   = 1'b1;
          mem_wr_data = '{glyph: plot.glyph, depth: plot.depth};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frm.sin_tilt <= '0;
      frm.cos_tilt <= Q_W'(16384);
      frm.sin_spin <= '0;
      frm.cos_spin <= Q_W'(16384);
    end else if (cfg_wr_en) begin
      unique case (cfg_reg_e'(cfg_index))
        REG_SIN_TILT: frm.sin_tilt <= cfg_data;
        REG_COS_TILT: frm.cos_tilt <= cfg_data;
        REG_SIN_SPIN: frm.sin_spin <= cfg_data;
        REG_COS_SPIN: frm.cos_spin <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_addr  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (result.ready) out_valid <= 1'b0;
      unique case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + ADDR_W'(1);
          if (clr_addr == ADDR_W'(CELLS - 1)) state <= ST_IDLE;
        end
        ST_IDLE: begin
          if (accept) begin
            cur_read <= sample.payload.mode;
            cur_cell <= sample.payload.cell_index;
            cur_nl   <= is_row_start(sample.payload.cell_index);
            if (!sample.payload.mode) begin
              state <= ST_GEOM;
            end else if (in_store) begin
              state <= ST_LOOK;
            end else begin
              res.plotted     <= 1'b0;
              res.target_cell <= sample.payload.cell_index;
              res.glyph       <= is_row_start(sample.payload.cell_index) ?
                                 GLYPH_NEWLINE : GLYPH_SPACE;
              state           <= ST_DONE;
            end
          end
        end
        ST_GEOM: begin
          if (geom_done) begin
            cur_cell <= plot.cell_num;
            if (plot.in_bounds) begin
              state <= ST_LOOK;
            end else begin
              res   <= '0;
              state <= ST_DONE;
            end
          end
        end
        ST_LOOK: begin
          if (cur_read) begin
            res.plotted     <= 1'b0;
            res.target_cell <= cur_cell;
            res.glyph       <= cur_nl ? GLYPH_NEWLINE : mem_rd_data.glyph;
          end else if (hit) begin
            res.plotted     <= 1'b1;
            res.target_cell <= cur_cell;
            res.glyph       <= plot.glyph;
          end else begin
            res <= '0;
          end
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (!out_valid || result.ready) begin
            out_valid <= 1'b1;
            out_word  <= res;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_clear_blocks: assert property (@(posedge clk) disable iff (rst)
    state == ST_CLEAR |-> !sample.ready)
    else $error("sample accepted during the clearing pass");

  a_port_excl: assert property (@(posedge clk) disable iff (rst)
    mem_wr_en |-> !mem_rd_en)
    else $error("store read and write in the same cycle");

  a_geom_state: assert property (@(posedge clk) disable iff (rst)
    geom_done |-> state == ST_GEOM)
    else $error("projection finished outside a plot word");

  a_plot_glyph: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word.plotted |->
      out_word.glyph != GLYPH_NEWLINE && out_word.glyph != GLYPH_SPACE)
    else $error("plotted word carries a non-shade glyph");

endmodule
